// ===== rtl/core/gdn_pkg.sv =====
// Shared types, calendar constants and the month length table for the day number converter.
package gdn_pkg;

	localparam int YEAR_W  = 14;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int COUNT_W = 22;

	localparam logic OP_TO_COUNT = 1'b0;
	localparam logic OP_TO_DATE  = 1'b1;

	localparam logic [YEAR_W-1:0]  MAX_YEAR  = 14'd9999;
	localparam logic [COUNT_W-1:0] MAX_COUNT = 22'd3652424;

	localparam logic [COUNT_W-1:0] DAYS_400Y       = 22'd146097;
	localparam logic [COUNT_W-1:0] DAYS_100Y_FIRST = 22'd36525;
	localparam logic [COUNT_W-1:0] DAYS_100Y       = 22'd36524;
	localparam logic [COUNT_W-1:0] DAYS_4Y         = 22'd1461;
	localparam logic [COUNT_W-1:0] DAYS_4Y_SHORT   = 22'd1460;
	localparam logic [COUNT_W-1:0] DAYS_LEAP_YEAR  = 22'd366;
	localparam logic [COUNT_W-1:0] DAYS_YEAR       = 22'd365;

	localparam logic [COUNT_W-1:0] YEARS_400 = 22'd400;
	localparam logic [COUNT_W-1:0] YEARS_100 = 22'd100;
	localparam logic [COUNT_W-1:0] YEARS_4   = 22'd4;
	localparam logic [COUNT_W-1:0] YEARS_1   = 22'd1;

	typedef struct packed {
		logic               opcode;
		logic [YEAR_W-1:0]  in_year;
		logic [MONTH_W-1:0] in_month;
		logic [DAY_W-1:0]   in_day;
		logic [COUNT_W-1:0] in_day_count;
	} gdn_req_t;

	typedef struct packed {
		logic [COUNT_W-1:0] out_day_count;
		logic [YEAR_W-1:0]  out_year;
		logic [MONTH_W-1:0] out_month;
		logic [DAY_W-1:0]   out_day;
		logic               bad_input;
	} gdn_rsp_t;

	typedef struct packed {
		logic               load;
		logic [COUNT_W-1:0] rem_init;
		logic [COUNT_W-1:0] acc_init;
		logic               step_en;
		logic [COUNT_W-1:0] step;
		logic [COUNT_W-1:0] weight;
	} gdn_cmd_t;

	typedef struct packed {
		logic               borrow;
		logic [COUNT_W-1:0] rem;
		logic [COUNT_W-1:0] acc;
	} gdn_sts_t;

	function automatic logic [DAY_W-1:0] month_len(input logic leap,
		input logic [MONTH_W-1:0] month);
		logic [DAY_W-1:0] len;
		case (month) inside
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
			4'd2: len = leap ? 5'd29 : 5'd28;
			default: len = 5'd0;
		endcase
		return len;
	endfunction

endpackage

// ===== rtl/core/gdn_unit.sv =====
// Shared compare, subtract and accumulate unit for the day number converter.
module gdn_unit (
	input  logic              clk,
	input  gdn_pkg::gdn_cmd_t cmd,
	output gdn_pkg::gdn_sts_t sts
);

	logic [gdn_pkg::COUNT_W-1:0] rem_q;
	logic [gdn_pkg::COUNT_W-1:0] acc_q;
	logic                        borrow;

	assign borrow = rem_q < cmd.step;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rem_q <= cmd.rem_init;
			acc_q <= cmd.acc_init;
		end else if (cmd.step_en && !borrow) begin
			rem_q <= rem_q - cmd.step;
			acc_q <= acc_q + cmd.weight;
		end
	end

	assign sts.borrow = borrow;
	assign sts.rem    = rem_q;
	assign sts.acc    = acc_q;

endmodule

// ===== rtl/core/gdn_ctrl.sv =====
// Sequencer that walks the 400-year, century, 4-year, year and month levels.
module gdn_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  gdn_pkg::gdn_req_t req,
	input  logic              deliver,
	output logic              idle,
	output logic              done,
	output gdn_pkg::gdn_rsp_t rsp,
	output gdn_pkg::gdn_cmd_t cmd,
	input  gdn_pkg::gdn_sts_t sts
);

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_Y400 = 7'b0000010,
		S_Y100 = 7'b0000100,
		S_Y4   = 7'b0001000,
		S_Y1   = 7'b0010000,
		S_MON  = 7'b0100000,
		S_DONE = 7'b1000000
	} state_t;

	state_t                        state_q, state_d;
	logic                          op_q;
	logic [gdn_pkg::MONTH_W-1:0]   month_q;
	logic [gdn_pkg::DAY_W-1:0]     day_q;
	logic                          bad_q, bad_d;
	logic [1:0]                    c_q;
	logic [4:0]                    b_q;
	logic [1:0]                    k_q;
	logic [gdn_pkg::MONTH_W-1:0]   m_q;

	logic                          fwd;
	logic                          fwd_in;
	logic                          early_bad;
	logic                          leap;
	logic [gdn_pkg::DAY_W-1:0]     mlen;
	logic [gdn_pkg::DAY_W-1:0]     in_mlen;
	logic [gdn_pkg::COUNT_W-1:0]   cdays;
	logic [gdn_pkg::COUNT_W-1:0]   bdays;
	logic [gdn_pkg::COUNT_W-1:0]   ydays;
	logic                          advance;

	assign fwd     = op_q == gdn_pkg::OP_TO_COUNT;
	assign fwd_in  = req.opcode == gdn_pkg::OP_TO_COUNT;
	assign leap    = (k_q == 2'd0) && ((b_q != 5'd0) || (c_q == 2'd0));
	assign mlen    = gdn_pkg::month_len(leap, m_q);
	assign in_mlen = gdn_pkg::month_len(leap, month_q);
	assign cdays   = (c_q == 2'd0) ? gdn_pkg::DAYS_100Y_FIRST : gdn_pkg::DAYS_100Y;
	assign bdays   = ((c_q == 2'd0) || (b_q != 5'd0)) ? gdn_pkg::DAYS_4Y
		: gdn_pkg::DAYS_4Y_SHORT;
	assign ydays   = leap ? gdn_pkg::DAYS_LEAP_YEAR : gdn_pkg::DAYS_YEAR;

	always_comb begin
		if (fwd_in) begin
			early_bad = (req.in_year > gdn_pkg::MAX_YEAR) || (req.in_month == 4'd0)
				|| (req.in_month > 4'd12) || (req.in_day == 5'd0);
		end else begin
			early_bad = req.in_day_count > gdn_pkg::MAX_COUNT;
		end
	end

	always_comb begin
		cmd.load     = 1'b0;
		cmd.rem_init = '0;
		cmd.acc_init = '0;
		cmd.step_en  = 1'b0;
		cmd.step     = '0;
		cmd.weight   = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.load = start;
				if (fwd_in) begin
					cmd.rem_init = {{(gdn_pkg::COUNT_W-gdn_pkg::YEAR_W){1'b0}}, req.in_year};
					cmd.acc_init = {{(gdn_pkg::COUNT_W-gdn_pkg::DAY_W){1'b0}}, req.in_day}
						- 22'd1;
				end else begin
					cmd.rem_init = req.in_day_count;
				end
			end
			S_Y400: begin
				cmd.step_en = 1'b1;
				cmd.step    = fwd ? gdn_pkg::YEARS_400 : gdn_pkg::DAYS_400Y;
				cmd.weight  = fwd ? gdn_pkg::DAYS_400Y : gdn_pkg::YEARS_400;
			end
			S_Y100: begin
				cmd.step_en = 1'b1;
				cmd.step    = fwd ? gdn_pkg::YEARS_100 : cdays;
				cmd.weight  = fwd ? cdays : gdn_pkg::YEARS_100;
			end
			S_Y4: begin
				cmd.step_en = 1'b1;
				cmd.step    = fwd ? gdn_pkg::YEARS_4 : bdays;
				cmd.weight  = fwd ? bdays : gdn_pkg::YEARS_4;
			end
			S_Y1: begin
				cmd.step_en = 1'b1;
				cmd.step    = fwd ? gdn_pkg::YEARS_1 : ydays;
				cmd.weight  = fwd ? ydays : gdn_pkg::YEARS_1;
			end
			S_MON: begin
				if (fwd) begin
					cmd.step_en = m_q != month_q;
					cmd.weight  = {{(gdn_pkg::COUNT_W-gdn_pkg::DAY_W){1'b0}}, mlen};
				end else begin
					cmd.step_en = 1'b1;
					cmd.step    = {{(gdn_pkg::COUNT_W-gdn_pkg::DAY_W){1'b0}}, mlen};
				end
			end
			S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	assign advance = cmd.step_en && !sts.borrow;

	always_comb begin
		state_d = state_q;
		bad_d   = bad_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					bad_d   = early_bad;
					state_d = early_bad ? S_DONE : S_Y400;
				end
			end
			S_Y400: if (!advance) state_d = S_Y100;
			S_Y100: if (!advance) state_d = S_Y4;
			S_Y4:   if (!advance) state_d = S_Y1;
			S_Y1: begin
				if (!advance) begin
					if (fwd && (day_q > in_mlen)) begin
						bad_d   = 1'b1;
						state_d = S_DONE;
					end else begin
						state_d = S_MON;
					end
				end
			end
			S_MON: begin
				if (fwd ? (m_q == month_q) : sts.borrow) state_d = S_DONE;
			end
			S_DONE: if (deliver) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			c_q     <= 2'd0;
			b_q     <= 5'd0;
			k_q     <= 2'd0;
			m_q     <= 4'd1;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE) begin
				c_q <= 2'd0;
				b_q <= 5'd0;
				k_q <= 2'd0;
				m_q <= 4'd1;
			end else if (advance) begin
				if (state_q == S_Y100) c_q <= c_q + 2'd1;
				if (state_q == S_Y4)   b_q <= b_q + 5'd1;
				if (state_q == S_Y1)   k_q <= k_q + 2'd1;
				if (state_q == S_MON)  m_q <= m_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		bad_q <= bad_d;
		if (state_q == S_IDLE && start) begin
			op_q    <= req.opcode;
			month_q <= req.in_month;
			day_q   <= req.in_day;
		end
	end

	assign idle = state_q == S_IDLE;
	assign done = state_q == S_DONE;

	assign rsp.out_day_count = (fwd && !bad_q) ? sts.acc : '0;
	assign rsp.out_year      = (!fwd && !bad_q) ? sts.acc[gdn_pkg::YEAR_W-1:0] : '0;
	assign rsp.out_month     = (!fwd && !bad_q) ? m_q : '0;
	assign rsp.out_day       = (!fwd && !bad_q) ? (sts.rem[gdn_pkg::DAY_W-1:0] + 5'd1) : '0;
	assign rsp.bad_input     = bad_q;

	a_century_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_Y100 && advance) |-> (c_q != 2'd3))
		else $error("century index overflow");

	a_block_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_Y4 && advance) |-> (b_q < 5'd24))
		else $error("4-year block index overflow");

	a_year_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_Y1 && advance) |-> (k_q != 2'd3))
		else $error("year index overflow");

	a_date_sane: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && !fwd && !bad_q) |->
		(m_q >= 4'd1 && m_q <= 4'd12
		&& sts.rem < {{(gdn_pkg::COUNT_W-gdn_pkg::DAY_W){1'b0}}, mlen}))
		else $error("reverse result outside its month");

endmodule

// ===== rtl/core/gregorian_day_number_converter_top.sv =====
// Top level of the proleptic Gregorian date and day number converter.
// Opcode 0 turns year, month and day into the count of days since 1 January of year 0;
// opcode 1 turns such a count back into a date. Year 0 is a leap year and the calendar
// repeats every 400 years. One request is worked at a time by a single shared
// compare-subtract-accumulate unit stepping through 400-year cycles, centuries, 4-year
// blocks, years and months; a request holds the block for as many steps as it takes at
// each of those levels plus one more to end each level, while an input rejected on arrival
// goes straight to done. req_ready is high only while the sequencer is idle.
// Results go to an output register, so the next request is taken while an earlier
// result still waits for rsp_ready.
module gregorian_day_number_converter_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  gdn_pkg::gdn_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output gdn_pkg::gdn_rsp_t rsp
);

	gdn_pkg::gdn_cmd_t cmd;
	gdn_pkg::gdn_sts_t sts;
	gdn_pkg::gdn_rsp_t result;
	gdn_pkg::gdn_rsp_t rsp_q;
	logic              rsp_valid_q;
	logic              idle;
	logic              done;
	logic              start;
	logic              deliver;

	assign start   = req_valid && idle;
	assign deliver = done && (!rsp_valid_q || rsp_ready);

	gdn_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.req     (req),
		.deliver (deliver),
		.idle    (idle),
		.done    (done),
		.rsp     (result),
		.cmd     (cmd),
		.sts     (sts)
	);

	gdn_unit u_unit (
		.clk (clk),
		.cmd (cmd),
		.sts (sts)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (deliver) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (deliver) begin
			rsp_q <= result;
		end
	end

	assign req_ready = idle;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the Gregorian date and day number converter.
`timescale 1ns / 1ps

module testbench;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES  = 100;
	localparam int RANDOM_ITEMS   = 500;

	typedef struct {
		gdn_pkg::gdn_req_t req;
		bit                drain_first;
	} pending_t;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              req_valid = 1'b0;
	logic              req_ready;
	gdn_pkg::gdn_req_t req       = '0;
	logic              rsp_valid;
	logic              rsp_ready = 1'b0;
	gdn_pkg::gdn_rsp_t rsp;

	pending_t          pending_reqs[$];
	gdn_pkg::gdn_rsp_t expected_rsps[$];
	int                n_sent      = 0;
	int                total_items = 0;
	int                errors      = 0;
	int                idle_cycles = 0;
	int                phase;
	int                sender_idle_pct;
	int                receiver_stall_pct;

	gregorian_day_number_converter_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	assign phase              = (total_items != 0) ? (n_sent * 4) / total_items : 0;
	assign sender_idle_pct    = (phase == 1) ? 66 : (phase == 3) ? 29 : 0;
	assign receiver_stall_pct = (phase == 2) ? 66 : (phase == 3) ? 29 : 0;

	function automatic bit is_leap(int unsigned y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	function automatic int unsigned days_in_month(bit leap, int unsigned m);
		int unsigned n;
		case (m)
			2: n = leap ? 29 : 28;
			4, 6, 9, 11: n = 30;
			1, 3, 5, 7, 8, 10, 12: n = 31;
			default: n = 0;
		endcase
		return n;
	endfunction

	function automatic int unsigned days_to_year(int unsigned y);
		return y * 365 + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
	endfunction

	function automatic gdn_pkg::gdn_rsp_t predict_conversion(gdn_pkg::gdn_req_t r);
		gdn_pkg::gdn_rsp_t o;
		int unsigned       y, m, d, c, rem;
		bit                lp;
		o = '0;
		if (r.opcode == gdn_pkg::OP_TO_COUNT) begin
			y  = r.in_year;
			m  = r.in_month;
			d  = r.in_day;
			lp = is_leap(y);
			if (y > gdn_pkg::MAX_YEAR || m < 1 || m > 12 || d < 1
				|| d > days_in_month(lp, m)) begin
				o.bad_input = 1'b1;
			end else begin
				c = days_to_year(y);
				for (int i = 1; i < m; i++)
					c += days_in_month(lp, i);
				o.out_day_count = 22'(c + d - 1);
			end
		end else begin
			c = r.in_day_count;
			if (c > gdn_pkg::MAX_COUNT) begin
				o.bad_input = 1'b1;
			end else begin
				y   = (c / gdn_pkg::DAYS_400Y) * 400;
				rem = c % gdn_pkg::DAYS_400Y;
				while (rem >= 365 + is_leap(y)) begin
					rem -= 365 + is_leap(y);
					y++;
				end
				lp = is_leap(y);
				m  = 1;
				while (m < 12 && rem >= days_in_month(lp, m)) begin
					rem -= days_in_month(lp, m);
					m++;
				end
				o.out_year  = 14'(y);
				o.out_month = 4'(m);
				o.out_day   = 5'(rem + 1);
			end
		end
		return o;
	endfunction

	// fill the unused direction with noise
	function automatic gdn_pkg::gdn_req_t directed_req(logic op, int unsigned y,
		int unsigned m, int unsigned d, int unsigned c);
		gdn_pkg::gdn_req_t r;
		logic [63:0]       noise;
		noise = {$urandom, $urandom};
		r     = noise[$bits(gdn_pkg::gdn_req_t)-1:0];
		r.opcode = op;
		if (op == gdn_pkg::OP_TO_COUNT) begin
			r.in_year  = 14'(y);
			r.in_month = 4'(m);
			r.in_day   = 5'(d);
		end else begin
			r.in_day_count = 22'(c);
		end
		return r;
	endfunction

	function automatic gdn_pkg::gdn_req_t random_request();
		gdn_pkg::gdn_req_t r;
		logic [63:0]       noise;
		int unsigned       sel, lim;
		noise = {$urandom, $urandom};
		r     = noise[$bits(gdn_pkg::gdn_req_t)-1:0];
		sel   = $urandom_range(99);
		if (r.opcode == gdn_pkg::OP_TO_COUNT) begin
			if (sel < 88) begin
				case ($urandom_range(3))
					0: r.in_year = 14'(100 * $urandom_range(99) + $urandom_range(4));
					1: r.in_year = 14'($urandom_range(8));
					default: r.in_year = 14'($urandom_range(gdn_pkg::MAX_YEAR));
				endcase
				r.in_month = 4'($urandom_range(12, 1));
				lim = days_in_month(is_leap(r.in_year), r.in_month);
				r.in_day = 5'(($urandom_range(3) == 0) ? lim : $urandom_range(lim, 1));
			end
		end else if (sel < 90) begin
			case ($urandom_range(3))
				0: r.in_day_count = 22'(days_to_year($urandom_range(gdn_pkg::MAX_YEAR, 1))
					- $urandom_range(1));
				default: r.in_day_count = 22'($urandom_range(gdn_pkg::MAX_COUNT));
			endcase
		end
		return r;
	endfunction

	task automatic add_request(gdn_pkg::gdn_req_t r, bit drain);
		pending_t p;
		p.req         = r;
		p.drain_first = drain;
		pending_reqs.push_back(p);
	endtask

	task automatic report_mismatch(string what);
		$display("mismatch: %s", what);
		errors++;
	endtask

	task automatic check_field(string name, int unsigned got, int unsigned want);
		if (got != want)
			report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		pending_t nxt;
		if (!arst_n) begin
			req_valid <= 1'b0;
			req       <= '0;
		end else begin
			if (req_valid && req_ready) begin
				expected_rsps.push_back(predict_conversion(req));
				n_sent <= n_sent + 1;
			end
			if (!req_valid || req_ready) begin
				if (pending_reqs.size() == 0) begin
					req_valid <= 1'b0;
				end else if (pending_reqs[0].drain_first && expected_rsps.size() != 0) begin
					req_valid <= 1'b0;
				end else if ($urandom_range(99) < sender_idle_pct) begin
					req_valid <= 1'b0;
				end else begin
					nxt        = pending_reqs.pop_front();
					req_valid <= 1'b1;
					req       <= nxt.req;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		gdn_pkg::gdn_rsp_t want;
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (expected_rsps.size() == 0) begin
					report_mismatch($sformatf("unexpected response %h", rsp));
				end else begin
					want = expected_rsps.pop_front();
					check_field("out_day_count", rsp.out_day_count, want.out_day_count);
					check_field("out_year", rsp.out_year, want.out_year);
					check_field("out_month", rsp.out_month, want.out_month);
					check_field("out_day", rsp.out_day, want.out_day);
					check_field("bad_input", rsp.bad_input, want.bad_input);
				end
			end
			rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("[gregorian_day_number_converter_top] ERROR");
				$finish;
			end
		end
	end

	initial begin
		int n_directed;
		add_request(directed_req(gdn_pkg::OP_TO_COUNT, 0, 1, 1, 0), 1'b0);
		add_request(directed_req(gdn_pkg::OP_TO_COUNT, 0, 2, 29, 0), 1'b0);
		add_request(directed_req(gdn_pkg::OP_TO_COUNT, 0, 12, 31, 0), 1'b0);
		add_request(directed_req(gdn_pkg::OP_TO_COUNT, 9999, 12, 31, 0), 1'b0);
		add_request(directed_req(gdn_pkg::OP_TO_COUNT, 2000, 2, 29, 0), 1'b0);
		add_request(directed_req(gdn_pkg::OP_TO_COUNT, 1900, 2, 29, 0), 1'b0);
		add_request(directed_req(gdn_pkg::OP_TO_COUNT, 1900, 2, 28, 0), 1'b0);
		add_request(directed_req(gdn_pkg::OP_TO_COUNT, 2024, 3, 1, 0), 1'b0);
		add_request(directed_req(gdn_pkg::OP_TO_COUNT, 10000, 1, 1, 0), 1'b0);
		add_request(directed_req(gdn_pkg::OP_TO_COUNT, 16383, 15, 31, 0), 1'b0);
		add_request(directed_req(gdn_pkg::OP_TO_COUNT, 2023, 0, 10, 0), 1'b0);
		add_request(directed_req(gdn_pkg::OP_TO_COUNT, 2023, 13, 1, 0), 1'b0);
		add_request(directed_req(gdn_pkg::OP_TO_COUNT, 2023, 6, 0, 0), 1'b0);
		add_request(directed_req(gdn_pkg::OP_TO_COUNT, 2023, 4, 31, 0), 1'b0);
		add_request(directed_req(gdn_pkg::OP_TO_COUNT, 1, 1, 1, 0), 1'b0);
		add_request(directed_req(gdn_pkg::OP_TO_DATE, 0, 0, 0, 0), 1'b0);
		add_request(directed_req(gdn_pkg::OP_TO_DATE, 0, 0, 0, 59), 1'b0);
		add_request(directed_req(gdn_pkg::OP_TO_DATE, 0, 0, 0, 365), 1'b0);
		add_request(directed_req(gdn_pkg::OP_TO_DATE, 0, 0, 0, 366), 1'b0);
		add_request(directed_req(gdn_pkg::OP_TO_DATE, 0, 0, 0, gdn_pkg::MAX_COUNT), 1'b0);
		add_request(directed_req(gdn_pkg::OP_TO_DATE, 0, 0, 0, gdn_pkg::MAX_COUNT + 1),
			1'b0);
		add_request(directed_req(gdn_pkg::OP_TO_DATE, 0, 0, 0, 22'h3FFFFF), 1'b0);
		add_request(directed_req(gdn_pkg::OP_TO_DATE, 0, 0, 0, gdn_pkg::DAYS_400Y - 1),
			1'b0);
		add_request(directed_req(gdn_pkg::OP_TO_DATE, 0, 0, 0, gdn_pkg::DAYS_400Y), 1'b0);
		add_request(directed_req(gdn_pkg::OP_TO_DATE, 0, 0, 0, 36525), 1'b0);
		n_directed = pending_reqs.size();
		for (int i = 0; i < RANDOM_ITEMS; i++)
			add_request(random_request(),
				(i % (RANDOM_ITEMS / 4) == 0) || ($urandom_range(49) == 0));
		total_items = n_directed + RANDOM_ITEMS;

		repeat (9) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (errors == 0)
			$display("[gregorian_day_number_converter_top] OK");
		else
			$display("[gregorian_day_number_converter_top] ERROR");
		$finish;
	end

endmodule
